// ----- rtl/aofc_pkg.sv -----
// Shared types and constants for the box overlap and face classifier.
`default_nettype none

package aofc_pkg;

	// Width of one signed edge coordinate
	localparam int COORD_BITS = 16;

	// Face of box A that box B touches
	typedef enum logic [2:0] {
		FACE_NONE      = 3'd0,
		FACE_TOP       = 3'd1,
		FACE_BOTTOM    = 3'd2,
		FACE_LEFT      = 3'd3,
		FACE_RIGHT     = 3'd4,
		FACE_CONTAINED = 3'd5
	} face_t;

	// One input item: the edges of both boxes
	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_left;
		logic signed [COORD_BITS-1:0] a_right;
		logic signed [COORD_BITS-1:0] a_bottom;
		logic signed [COORD_BITS-1:0] a_top;
		logic signed [COORD_BITS-1:0] b_left;
		logic signed [COORD_BITS-1:0] b_right;
		logic signed [COORD_BITS-1:0] b_bottom;
		logic signed [COORD_BITS-1:0] b_top;
	} box_pair_t;

	// One result item
	typedef struct packed {
		logic  overlap;
		face_t face;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/aofc_overlap.sv -----
// Overlap test on doubled centers and doubled extents of two boxes.
`default_nettype none

module aofc_overlap (
	input  aofc_pkg::box_pair_t box,
	output logic                overlap
);
	import aofc_pkg::*;

	// Doubled center minus doubled extent needs three extra bits
	localparam int SW = COORD_BITS + 3;

	logic signed [SW-1:0] al, ar, ab, at, bl, br, bb, bt;
	logic signed [SW-1:0] cxa, cya, cxb, cyb, w2, h2;

	// Sign-extend all edges to the working width
	assign al = SW'(box.a_left);
	assign ar = SW'(box.a_right);
	assign ab = SW'(box.a_bottom);
	assign at = SW'(box.a_top);
	assign bl = SW'(box.b_left);
	assign br = SW'(box.b_right);
	assign bb = SW'(box.b_bottom);
	assign bt = SW'(box.b_top);

	// Doubled centers and summed extents
	assign cxa = al + ar;
	assign cya = ab + at;
	assign cxb = bl + br;
	assign cyb = bb + bt;
	assign w2  = (ar - al) + (br - bl);
	assign h2  = (at - ab) + (bt - bb);

	// Center distance within summed extents on both axes, touching included
	assign overlap = (cxb >= cxa - w2) && (cxb <= cxa + w2) &&
	                 (cyb >= cya - h2) && (cyb <= cya + h2);

endmodule

`default_nettype wire

// ----- rtl/aofc_face.sv -----
// Face selection for an overlapping box pair from edge compares and tie-breaks.
`default_nettype none

module aofc_face (
	input  aofc_pkg::box_pair_t box,
	output aofc_pkg::face_t     face
);
	import aofc_pkg::*;

	// Edge differences carry one extra bit
	localparam int DW = COORD_BITS + 1;

	// Absolute value of a signed difference, as unsigned of the same width
	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] d);
		logic [DW-1:0] r;
		r = d[DW-1] ? (~d + DW'(1)) : d;
		return r;
	endfunction

	logic          up, dn, rt, lf;
	logic [DW-1:0] m_right_left, m_left_right, m_top_bottom, m_bottom_top;
	logic          hx_lf_top, hx_rt_top, hx_lf_bot, hx_rt_bot;

	// Which sides of A box B reaches or passes
	assign up = box.b_top >= box.a_top;
	assign dn = box.b_bottom <= box.a_bottom;
	assign rt = box.b_right >= box.a_right;
	assign lf = box.b_left <= box.a_left;

	// Penetration depths used for tie-breaks
	assign m_right_left = mag(DW'(box.b_right) - DW'(box.a_left));
	assign m_left_right = mag(DW'(box.a_right) - DW'(box.b_left));
	assign m_top_bottom = mag(DW'(box.a_top) - DW'(box.b_bottom));
	assign m_bottom_top = mag(DW'(box.b_top) - DW'(box.a_bottom));

	assign hx_lf_top = m_right_left > m_top_bottom;
	assign hx_rt_top = m_left_right > m_top_bottom;
	assign hx_lf_bot = m_right_left > m_bottom_top;
	assign hx_rt_bot = m_left_right > m_bottom_top;

	// Corner pairs first, then single sides, else B sits inside A
	always_comb begin
		if (up && lf) begin
			face = hx_lf_top ? FACE_TOP : FACE_LEFT;
		end else if (up && rt) begin
			face = hx_rt_top ? FACE_TOP : FACE_RIGHT;
		end else if (dn && lf) begin
			face = hx_lf_bot ? FACE_BOTTOM : FACE_LEFT;
		end else if (dn && rt) begin
			face = hx_rt_bot ? FACE_BOTTOM : FACE_RIGHT;
		end else if (up) begin
			face = FACE_TOP;
		end else if (dn) begin
			face = FACE_BOTTOM;
		end else if (rt) begin
			face = FACE_RIGHT;
		end else if (lf) begin
			face = FACE_LEFT;
		end else begin
			face = FACE_CONTAINED;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/aabb_overlap_face_classifier.sv -----
// Top level: input register, overlap and face logic, result register.
//
// Box-pair classifier. The box channel (box_valid, box_stall, box) carries the
// eight signed edges of boxes A and B; the result channel (result_valid,
// result_stall, result) returns the overlap flag and the touched face of A.
// An item moves on either channel at a clock edge where valid is high and
// stall is low.
// A result passes from the input register through the overlap and face logic
// into the result register, where the receiver can take it.
// Throughput: one item per cycle while the receiver does not stall; the whole
// test is a single pass of compares and adds between the two registers.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, and box_stall rises only when both registers are
// full and the result is not taken.
// Reset (arst_n low, asynchronous) empties both registers; no item is lost or
// produced across reset beyond those dropped.
`default_nettype none

module aabb_overlap_face_classifier (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                box_valid,
	output logic                box_stall,
	input  aofc_pkg::box_pair_t box,
	output logic                result_valid,
	input  logic                result_stall,
	output aofc_pkg::result_t   result
);
	import aofc_pkg::*;

	logic      valid_s1, valid_s2;
	box_pair_t box_s1;
	result_t   result_s2;
	logic      adv_s1, adv_s2;
	logic      hit;
	face_t     face_sel;
	result_t   result_d;

	// Stage enables: a stage loads when it is empty or drains this cycle
	assign adv_s2    = !valid_s2 || !result_stall;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign box_stall = !adv_s1;

	aofc_overlap u_overlap (
		.box     (box_s1),
		.overlap (hit)
	);

	aofc_face u_face (
		.box  (box_s1),
		.face (face_sel)
	);

	// Drop the face on a miss
	always_comb begin
		result_d.overlap = hit;
		result_d.face    = hit ? face_sel : FACE_NONE;
	end

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= box_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Hold or load payload registers
	always_ff @(posedge clk) begin
		if (adv_s1 && box_valid) begin
			box_s1 <= box;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_d;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// A miss always reports no face
	a_miss_no_face: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.overlap |-> result.face == FACE_NONE)
		else $error("miss reported with a face");

	// A hit always reports a face
	a_hit_has_face: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overlap |-> result.face != FACE_NONE)
		else $error("hit reported without a face");

	// Stall only while both the input and the result register hold an item
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		box_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with free room");

	// An item in the input register moves into an empty result register
	a_fill_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("item did not reach the result register");

endmodule

`default_nettype wire
